// File: rtl/core/posc_pkg.sv
// ----------------------------------------------------------------------------
// posc_pkg
// Shared types and codes of the periodic object send scheduler.
// ----------------------------------------------------------------------------
package posc_pkg;

  localparam int MAX_OBJECTS_DEF = 16;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_SET_PLAIN = 3'd1;
  localparam logic [2:0] OP_SET_TIMED = 3'd2;
  localparam logic [2:0] OP_CLEAR     = 3'd3;
  localparam logic [2:0] OP_SYNC      = 3'd4;

  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_TIMED = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  typedef struct packed {
    logic        auto_send_enable;
    logic [4:0]  object_count;
  } cfg_t;

  typedef struct packed {
    logic        timed;
    logic [30:0] elapsed;
    logic [30:0] period;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  idx;
    logic [7:0]  addr;
    logic [30:0] per;
    logic [31:0] ts;
  } res_t;

endpackage

// File: rtl/core/periodic_object_send_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_object_send_scheduler
// Per-object periodic send timers held in a table, driven by tick requests.
// ----------------------------------------------------------------------------
// A tick walks the n bound objects (n at most MAX_OBJECTS) through the
// timer table, which has one registered read port: after the first read the
// walk handles one entry per cycle while no send waits on a stalled result
// channel, and a closing step bumps the timestamp. A tick with sends
// disabled or no bound objects only bumps the timestamp. A set request reads
// the entry, then writes it back and replies, waiting while the reply is
// held off by the result channel; an ignored set request, clear and sync
// are handled in the idle state on acceptance. Sends of a tick leave in
// index order, the last flagged by tlast; a set request gives one period
// reply. The table powers up empty with no clearing pass.
module periodic_object_send_scheduler #(
  parameter int MAX_OBJECTS = posc_pkg::MAX_OBJECTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // op
  input  logic [47:0] in_tdata,   // object_index[7:0], period[39:8], receiver_addr[47:40]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // kind
  output logic [79:0] out_tdata,  // object_index_res[7:0], receiver_addr_res[15:8],
                                  // period_value[46:16], timestamp[78:47], zero[79]
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);
  import posc_pkg::*;

  localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

  cfg_t             cfg_r, cfg_nxt;
  logic             st_re, st_we, tg_we, st_clr;
  logic [IDX_W-1:0] st_raddr, st_waddr;
  entry_t           st_rdata, st_wdata;
  logic [7:0]       tg_rdata, tg_wdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE: cfg_nxt.auto_send_enable = cfg_data[0];
        CFG_COUNT:  cfg_nxt.object_count     = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{auto_send_enable: 1'b1, object_count: 5'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  posc_ctrl #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .st_re      (st_re),
    .st_raddr   (st_raddr),
    .st_rdata   (st_rdata),
    .tg_rdata   (tg_rdata),
    .st_we      (st_we),
    .tg_we      (tg_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata),
    .tg_wdata   (tg_wdata),
    .st_clr     (st_clr)
  );

  posc_mem #(
    .DEPTH (MAX_OBJECTS),
    .AW    (IDX_W),
    .DW    ($bits(entry_t))
  ) u_timer_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (st_clr),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  posc_mem #(
    .DEPTH (MAX_OBJECTS),
    .AW    (IDX_W),
    .DW    (8)
  ) u_target_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (1'b0),
    .we    (tg_we),
    .waddr (st_waddr),
    .wdata (tg_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (tg_rdata)
  );

endmodule

// File: rtl/core/posc_mem.sv
// ----------------------------------------------------------------------------
// posc_mem
// Single-port-write, registered-read table with per-entry valid bits.
// ----------------------------------------------------------------------------
module posc_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0]    mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_q_r <= mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_q_r : '0;

endmodule

// File: rtl/core/posc_ctrl.sv
// ----------------------------------------------------------------------------
// posc_ctrl
// Request sequencer: walks the timer table on a tick, serves set requests.
// ----------------------------------------------------------------------------
module posc_ctrl #(
  parameter int MAX_OBJECTS = posc_pkg::MAX_OBJECTS_DEF,
  parameter int IDX_W       = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  posc_pkg::cfg_t        cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2:0]            in_tuser,
  input  logic [47:0]           in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [1:0]            out_tuser,
  output logic [79:0]           out_tdata,
  output logic                  out_tlast,
  output logic                  st_re,
  output logic [IDX_W-1:0]      st_raddr,
  input  posc_pkg::entry_t      st_rdata,
  input  logic [7:0]            tg_rdata,
  output logic                  st_we,
  output logic                  tg_we,
  output logic [IDX_W-1:0]      st_waddr,
  output posc_pkg::entry_t      st_wdata,
  output logic [7:0]            tg_wdata,
  output logic                  st_clr
);
  import posc_pkg::*;

  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
  localparam logic [8:0] MAX9 = 9'(MAX_OBJECTS);

  typedef enum logic [1:0] {S_IDLE, S_SET, S_WALK, S_END} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;
  logic              out_last_r, out_last_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  res_t              pend_r, pend_nxt;
  logic [31:0]       stamp_r, stamp_nxt;
  logic [7:0]        req_idx_r, req_idx_nxt;
  logic [31:0]       req_per_r, req_per_nxt;
  logic [7:0]        req_addr_r, req_addr_nxt;
  logic              req_timed_r, req_timed_nxt;

  logic [8:0]        oc_ext, n_ext;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  ptr_inc;
  logic              accept, out_free, adv;
  logic [30:0]       e1;
  logic              active, fire;
  logic [7:0]        in_idx, in_addr;
  logic [31:0]       in_per;
  logic              set_nonneg;
  logic [30:0]       set_per;

  assign oc_ext   = {4'd0, cfg.object_count};
  assign n_ext    = (oc_ext > MAX9) ? MAX9 : oc_ext;
  assign n        = n_ext[CNT_W-1:0];
  assign ptr_inc  = ptr_r + CNT_W'(1);
  assign in_idx   = in_tdata[7:0];
  assign in_per   = in_tdata[39:8];
  assign in_addr  = in_tdata[47:40];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign e1     = st_rdata.elapsed + 31'd1;
  assign active = (st_rdata.period != 31'd0);
  assign fire   = active && (e1 >= st_rdata.period);
  assign adv    = !(fire && pend_valid_r && !out_free);

  assign set_nonneg = !req_per_r[31];
  assign set_per    = set_nonneg ? req_per_r[30:0] : st_rdata.period;

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    stamp_nxt      = stamp_r;
    req_idx_nxt    = req_idx_r;
    req_per_nxt    = req_per_r;
    req_addr_nxt   = req_addr_r;
    req_timed_nxt  = req_timed_r;
    st_re          = 1'b0;
    st_raddr       = ptr_r[IDX_W-1:0];
    st_we          = 1'b0;
    tg_we          = 1'b0;
    st_waddr       = ptr_r[IDX_W-1:0];
    st_wdata       = st_rdata;
    tg_wdata       = req_addr_r;
    st_clr         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_tuser)
            OP_TICK: begin
              if (cfg.auto_send_enable && (n != '0)) begin
                st_re     = 1'b1;
                st_raddr  = '0;
                ptr_nxt   = '0;
                state_nxt = S_WALK;
              end else begin
                stamp_nxt = stamp_r + 32'd1;
              end
            end
            OP_SET_PLAIN, OP_SET_TIMED: begin
              if (cfg.auto_send_enable && ({1'b0, in_idx} < n_ext)) begin
                st_re         = 1'b1;
                st_raddr      = in_idx[IDX_W-1:0];
                req_idx_nxt   = in_idx;
                req_per_nxt   = in_per;
                req_addr_nxt  = in_addr;
                req_timed_nxt = (in_tuser == OP_SET_TIMED);
                state_nxt     = S_SET;
              end
            end
            OP_CLEAR: begin
              st_clr = 1'b1;
            end
            OP_SYNC: begin
              stamp_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SET: begin
        st_waddr = req_idx_r[IDX_W-1:0];
        st_wdata = '{timed:   st_rdata.timed | (set_nonneg & req_timed_r),
                     elapsed: st_rdata.elapsed,
                     period:  set_per};
        tg_wdata = req_addr_r;
        if (out_free) begin
          st_we         = set_nonneg;
          tg_we         = set_nonneg;
          out_valid_nxt = 1'b1;
          out_nxt       = '{kind: KIND_REPLY, idx: req_idx_r, addr: req_addr_r,
                            per: set_per, ts: 32'd0};
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WALK: begin
        st_wdata = '{timed:   st_rdata.timed,
                     elapsed: fire ? 31'd0 : e1,
                     period:  st_rdata.period};
        if (adv) begin
          st_we = active;
          if (fire) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_nxt = '{kind: st_rdata.timed ? KIND_TIMED : KIND_PLAIN,
                         idx: 8'(ptr_r), addr: tg_rdata,
                         per: st_rdata.period, ts: stamp_r};
          end
          if (ptr_inc == n) begin
            state_nxt = S_END;
          end else begin
            st_re    = 1'b1;
            st_raddr = ptr_inc[IDX_W-1:0];
            ptr_nxt  = ptr_inc;
          end
        end
      end
      S_END: begin
        if (!pend_valid_r) begin
          stamp_nxt = stamp_r + 32'd1;
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = pend_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          stamp_nxt      = stamp_r + 32'd1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ptr_r        <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      stamp_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      stamp_r      <= stamp_nxt;
    end
    out_r       <= out_nxt;
    out_last_r  <= out_last_nxt;
    pend_r      <= pend_nxt;
    req_idx_r   <= req_idx_nxt;
    req_per_r   <= req_per_nxt;
    req_addr_r  <= req_addr_nxt;
    req_timed_r <= req_timed_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_r.ts, out_r.per, out_r.addr, out_r.idx};

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_valid_r)
    else $error("pending send left over after walk");

  a_stall_holds_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && !adv) |-> !st_re ##1 $stable(ptr_r))
    else $error("walk advanced while stalled");

  a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    (st_we && st_re) |-> st_waddr != st_raddr)
    else $error("read and write of the same entry in one cycle");

  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_END && state_nxt == S_IDLE) |=>
      stamp_r == 32'($past(stamp_r) + 32'd1))
    else $error("timestamp not advanced after walk");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic object send scheduler. A driver feeds
// requests from a queue and a shadow timer table computes the sends and
// period replies each accepted request must cause. A monitor compares every
// result field by field, in order. Phases of random requests run under
// several enable and object count settings, with random idling on both
// sides and one long result-channel hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import posc_pkg::*;

  localparam int          MAX_OBJ         = MAX_OBJECTS_DEF;
  localparam int          OBJ_W           = (MAX_OBJ > 1) ? $clog2(MAX_OBJ) : 1;
  localparam int          DRAIN_CYCLES    = 2 * MAX_OBJ + 8;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          HOLD_AT         = 100;
  localparam int          HOLD_CYCLES     = 400;
  localparam logic [2:0]  OP_FIRST_UNUSED = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  idx;
    logic [31:0] per;
    logic [7:0]  addr;
  } sched_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  idx;
    logic [7:0]  addr;
    logic [30:0] per;
    logic [31:0] ts;
    logic        last;
  } send_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser   = '0;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [79:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = 1'b0;
  logic [4:0]  cfg_data   = '0;

  sched_req_t  request_queue[$];
  send_t       expected_sends[$];
  sched_req_t  cur_req;

  logic        cfg_enable;
  logic [4:0]  cfg_count;
  logic [30:0] obj_period[MAX_OBJ];
  logic [30:0] obj_elapsed[MAX_OBJ];
  logic [7:0]  obj_target[MAX_OBJ];
  logic        obj_timed[MAX_OBJ];
  logic [31:0] stamp;

  int          accepted_count = 0;
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          gap_left       = 0;
  int          stall_left     = 0;
  int          hold_left      = 0;
  bit          hold_done      = 1'b0;
  bit          quiet          = 1'b0;

  periodic_object_send_scheduler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned bound_objects();
    return (cfg_count > MAX_OBJ) ? MAX_OBJ : int'(cfg_count);
  endfunction

  function automatic void advance_timers(input sched_req_t r);
    send_t            s;
    int unsigned      n;
    int unsigned      first;
    int               i;
    logic [OBJ_W-1:0] j;
    n     = bound_objects();
    first = expected_sends.size();
    case (r.op)
      OP_TICK: begin
        if (cfg_enable) begin
          for (i = 0; i < n; i++) begin
            if (obj_period[i] != '0) begin
              obj_elapsed[i] = obj_elapsed[i] + 31'd1;
              if (obj_elapsed[i] >= obj_period[i]) begin
                obj_elapsed[i] = '0;
                s.kind = obj_timed[i] ? KIND_TIMED : KIND_PLAIN;
                s.idx  = i[7:0];
                s.addr = obj_target[i];
                s.per  = obj_period[i];
                s.ts   = stamp;
                s.last = 1'b0;
                expected_sends.insert(expected_sends.size(), s);
              end
            end
          end
        end
        stamp = stamp + 32'd1;
      end
      OP_SET_PLAIN, OP_SET_TIMED: begin
        if (cfg_enable && r.idx < n) begin
          j = r.idx[OBJ_W-1:0];
          if (!r.per[31]) begin
            obj_period[j] = r.per[30:0];
            obj_target[j] = r.addr;
            if (r.op == OP_SET_TIMED) obj_timed[j] = 1'b1;
          end
          s.kind = KIND_REPLY;
          s.idx  = r.idx;
          s.addr = r.addr;
          s.per  = obj_period[j];
          s.ts   = '0;
          s.last = 1'b0;
          expected_sends.insert(expected_sends.size(), s);
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < MAX_OBJ; i++) begin
          obj_period[i]  = '0;
          obj_elapsed[i] = '0;
          obj_timed[i]   = 1'b0;
        end
      end
      OP_SYNC: stamp = '0;
      default: ;
    endcase
    if (expected_sends.size() > first) begin
      s = expected_sends.pop_back();
      s.last = 1'b1;
      expected_sends.insert(expected_sends.size(), s);
    end
  endfunction

  function automatic sched_req_t random_req();
    sched_req_t  r;
    logic [31:0] u;
    int unsigned n;
    int unsigned pick;
    n      = bound_objects();
    u      = $urandom();
    r.op   = OP_TICK;
    r.idx  = u[7:0];
    r.addr = u[15:8];
    r.per  = $urandom();
    pick   = $urandom_range(0, 99);
    u      = $urandom_range(0, 1);
    if (pick < 45) begin
      r.op = OP_TICK;
    end else if (pick < 80) begin
      r.op = u[0] ? OP_SET_TIMED : OP_SET_PLAIN;
      if (n > 0) begin
        u     = $urandom_range(0, n - 1);
        r.idx = u[7:0];
      end
      if (pick < 70) begin
        if ($urandom_range(0, 4) == 0) r.per[31] = 1'b0;
        else r.per = $urandom_range(0, 6);
      end else begin
        r.per[31] = 1'b1;
      end
    end else if (pick < 85) begin
      r.op = u[0] ? OP_SET_TIMED : OP_SET_PLAIN;
    end else if (pick < 88) begin
      r.op = OP_CLEAR;
    end else if (pick < 92) begin
      r.op = OP_SYNC;
    end else if (pick < 95) begin
      u    = $urandom_range(0, 2);
      r.op = OP_FIRST_UNUSED + u[2:0];
    end else begin
      u    = $urandom();
      r.op = u[2:0];
    end
    return r;
  endfunction

  task automatic push_req(input logic [2:0] op, input logic [7:0] idx,
                          input logic [31:0] per, input logic [7:0] addr);
    sched_req_t r;
    r.op   = op;
    r.idx  = idx;
    r.per  = per;
    r.addr = addr;
    request_queue.insert(request_queue.size(), r);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ENABLE) cfg_enable = val[0];
    else cfg_count = val;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_tvalid || expected_sends.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // driver: predict on acceptance, then present the next request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_timers(cur_req);
        accepted_count <= accepted_count + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          cur_req = request_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_req.op;
          in_tdata  <= {cur_req.addr, cur_req.per, cur_req.idx};
          if (!quiet && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 8);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && accepted_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    send_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_sends.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind %0d idx %0d addr %0d per %0d ts %0d last %0d",
                   out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[46:16],
                   out_tdata[78:47], out_tlast);
      end else begin
        want = expected_sends.pop_front();
        if (out_tuser !== want.kind || out_tdata[7:0] !== want.idx ||
            out_tdata[15:8] !== want.addr || out_tdata[46:16] !== want.per ||
            out_tdata[78:47] !== want.ts || out_tdata[79] !== 1'b0 ||
            out_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected kind %0d idx %0d addr %0d per %0d ts %0d last %0d",
                     want.kind, want.idx, want.addr, want.per, want.ts, want.last);
            $display("          actual   kind %0d idx %0d addr %0d per %0d ts %0d last %0d pad %0b",
                     out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[46:16],
                     out_tdata[78:47], out_tlast, out_tdata[79]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    bit          ph_enable[7] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    logic [4:0]  ph_count[7]  = '{5'd16, 5'd5, 5'd16, 5'd0, 5'd31, 5'd1, 5'd16};
    int          ph_items[7]  = '{150, 50, 25, 15, 50, 20, 50};
    int          p;
    int          k;
    cfg_enable = 1'b1;
    cfg_count  = '0;
    stamp      = '0;
    for (k = 0; k < MAX_OBJ; k++) begin
      obj_period[k]  = '0;
      obj_elapsed[k] = '0;
      obj_target[k]  = '0;
      obj_timed[k]   = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_ENABLE, 5'd1);
    write_reg(CFG_COUNT, 5'd16);
    @(negedge clk);
    push_req(OP_SET_PLAIN, 8'd0,   32'd1,          8'hFF);
    push_req(OP_SET_TIMED, 8'd15,  32'd3,          8'h00);
    // plain set keeps the timed flag
    push_req(OP_SET_PLAIN, 8'd15,  32'd2,          8'h3C);
    push_req(OP_SET_PLAIN, 8'd0,   32'hFFFF_FFFF,  8'h11);
    push_req(OP_SET_TIMED, 8'd15,  32'h8000_0000,  8'h22);
    push_req(OP_SET_PLAIN, 8'd16,  32'd5,          8'h33);
    push_req(OP_SET_TIMED, 8'd255, 32'd5,          8'h44);
    push_req(OP_SET_PLAIN, 8'd3,   32'h7FFF_FFFF,  8'hA5);
    push_req(OP_SET_TIMED, 8'd7,   32'd4,          8'h5A);
    repeat (3) push_req(OP_TICK, 8'd0, 32'd0, 8'd0);
    // lower the period below the elapsed count
    push_req(OP_SET_PLAIN, 8'd7,   32'd2,          8'h5B);
    push_req(OP_TICK,      8'hFF,  32'hFFFF_FFFF,  8'hFF);
    push_req(OP_TICK,      8'd0,   32'd0,          8'd0);
    push_req(OP_SYNC,      8'd0,   32'd0,          8'd0);
    push_req(OP_TICK,      8'd0,   32'd0,          8'd0);
    for (k = 0; k < 3; k++) push_req(OP_FIRST_UNUSED + k[2:0], 8'd1, 32'd1, 8'd1);
    push_req(OP_SET_PLAIN, 8'd0,   32'd0,          8'h77);
    push_req(OP_TICK,      8'd0,   32'd0,          8'd0);
    push_req(OP_CLEAR,     8'd0,   32'd0,          8'd0);
    push_req(OP_TICK,      8'd0,   32'd0,          8'd0);
    push_req(OP_SET_PLAIN, 8'd15,  32'hFFFF_FFFF,  8'h66);

    for (p = 0; p < 7; p++) begin
      wait_drained();
      write_reg(CFG_ENABLE, {4'd0, ph_enable[p]});
      write_reg(CFG_COUNT, ph_count[p]);
      @(negedge clk);
      if (p == 6) quiet = 1'b1;
      for (k = 0; k < ph_items[p]; k++)
        request_queue.insert(request_queue.size(), random_req());
    end

    wait_drained();
    if (mismatch_count == 0 && expected_sends.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
